>>> hw/rtl/trd_pkg.sv
`timescale 1ns / 1ps
package trd_pkg;

  // default tile size
  localparam int TILE_W_DEF = 8;
  localparam int TILE_H_DEF = 8;

  // field widths
  localparam int COORD_W = 16;
  localparam int Z_W     = 24;
  localparam int PIX_W   = 3;
  localparam int WT_W    = 16;
  localparam int IN_W    = 168;
  localparam int OUT_W   = 64;

  // datapath widths
  localparam int DEN_W     = 36;
  localparam int EDGE_W    = 38;
  localparam int NUM_W     = 62;
  localparam int ACC_W     = 64;
  localparam int MA_W      = 25;
  localparam int MB_W      = 19;
  localparam int PROD_W    = MA_W + MB_W;
  localparam int HALF_W    = 18;
  localparam int MAC_IDX_W = 3;

  // divider step counts
  localparam int DIV_CNT_W    = 5;
  localparam int DEPTH_STEPS  = Z_W;
  localparam int WEIGHT_STEPS = WT_W;
  localparam int WT_FRAC      = 15;

  localparam logic [Z_W-1:0] DEPTH_ONES = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_POST, S_COVER, S_DDIV, S_DTEST,
    S_WDIVA, S_WDIVB, S_PUSH, S_NEXT, S_FLUSH
  } trd_state_e;

  typedef enum logic [1:0] {PH_DEN, PH_NA, PH_NB, PH_Z} trd_phase_e;

  typedef enum logic {REQ_RASTER = 1'b0, REQ_CLEAR = 1'b1} trd_req_e;

  typedef struct packed {
    logic clr;
    logic rd;
    logic wr;
  } trd_store_cmd_t;

  typedef struct packed {
    logic start;
    logic wmode;
  } trd_div_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [Z_W-1:0]   depth;
    logic [WT_W-1:0]  wa;
    logic [WT_W-1:0]  wb;
  } trd_pix_t;

endpackage

>>> hw/rtl/trd_store.sv
`timescale 1ns / 1ps
module trd_store import trd_pkg::*; #(
  parameter int DEPTH = TILE_W_DEF * TILE_H_DEF,
  parameter int AW    = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  trd_store_cmd_t cmd_i,
  input  logic [AW-1:0]  addr_i,
  input  logic [Z_W-1:0] wdata_i,
  output logic [Z_W-1:0] rdata_o
);

  logic [Z_W-1:0] mem [DEPTH];
  logic [Z_W-1:0] rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic rvld_q;

  // depth array, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  // per-entry valid bits, a cleared entry reads as infinitely far
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.wr) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rvld_q <= vld_q[addr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : DEPTH_ONES;

endmodule

>>> hw/rtl/trd_div.sv
`timescale 1ns / 1ps
module trd_div import trd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  trd_div_req_t     req_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Z_W-1:0]   quo_o
);

  logic [DEN_W:0] rem_q;
  logic [Z_W-1:0] bits_q;
  logic [Z_W-1:0] quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic busy_q;
  logic done_q;
  logic [DEN_W:0] trial;
  logic ge;

  // one restoring step per cycle
  assign trial = {rem_q[DEN_W-1:0], bits_q[Z_W-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.wmode ? DIV_CNT_W'(WEIGHT_STEPS) : DIV_CNT_W'(DEPTH_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient, the leading part of the dividend is known below den
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= '0;
      if (req_i.wmode) begin
        rem_q  <= {1'b0, num_i[DEN_W+WEIGHT_STEPS-1:WEIGHT_STEPS]};
        bits_q <= {num_i[WEIGHT_STEPS-1:0], (Z_W-WEIGHT_STEPS)'(0)};
      end else begin
        rem_q  <= {1'b0, num_i[DEN_W+DEPTH_STEPS-1:DEPTH_STEPS]};
        bits_q <= num_i[DEPTH_STEPS-1:0];
      end
    end else if (busy_q) begin
      rem_q  <= ge ? trial - {1'b0, den_i} : trial;
      bits_q <= {bits_q[Z_W-2:0], 1'b0};
      quo_q  <= {quo_q[Z_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> hw/rtl/triangle_raster_depth_test_top.sv
`timescale 1ns / 1ps
// Rasterises one triangle (or clears the depth store) per input beat. A triangle
// starts with a setup, then for every pixel of its clipped bounding box evaluates
// the edge functions on the shared 25x19 multiplier and steps to the next pixel;
// a covered pixel adds the depth sum and its 24-step division (the depth store
// read overlaps it), and a pixel that passes the depth test adds the two 16-step
// weight divisions of the radix-2 divider and a step to queue the beat. A clear
// leaves the block in its idle state: per-entry valid bits make every entry read
// as all ones at once. The input is ready only while no triangle is in progress;
// the output register lets the next triangle start while the final pixel of the
// last one waits to be taken.
module triangle_raster_depth_test_top import trd_pkg::*; #(
  parameter int TILE_WIDTH  = TILE_W_DEF,
  parameter int TILE_HEIGHT = TILE_H_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic             s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // pixel_x, pixel_y, depth, weight_a, weight_b, zero pad
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // last
  output logic             m_axis_tlast_o
);

  localparam int DEPTH = TILE_WIDTH * TILE_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic signed [COORD_W:0] q4_trunc(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W:0] e;
    logic signed [COORD_W:0] n;
    e = (COORD_W+1)'(v);
    n = -e;
    q4_trunc = v[COORD_W-1] ? -(n >>> 4) : (e >>> 4);
  endfunction

  trd_state_e state_q, state_d;
  trd_phase_e ph_q, ph_d;
  logic [MAC_IDX_W-1:0] idx_q, idx_d, mac_n;

  logic signed [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [Z_W-1:0] z0_q, z1_q, z2_q;

  logic signed [ACC_W-1:0] acc_q, acc_d, pext;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic psh_q, psh_d, pv_q, pv_d;
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic msh;

  logic [DEN_W-1:0] den_q, den_d;
  logic neg_q, neg_d;
  logic signed [EDGE_W-1:0] na_q, na_d, nb_q, nb_d, ng_q, ng_d, edge_val, ng_c;
  logic [PIX_W-1:0] bx0_q, bx0_d, bx1_q, bx1_d, by0_q, by0_d, by1_q, by1_d;
  logic [PIX_W-1:0] x_q, x_d, y_q, y_d;
  logic [Z_W-1:0] d_q, d_d;
  logic [WT_W-1:0] wa_q, wa_d, wb_q, wb_d;
  trd_pix_t pend_q, pend_d, out_q, out_d, cur;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d, out_last_q, out_last_d, out_load;

  logic s_acc, out_free, den_zero, box_empty, covered, pass, scan_end;
  logic signed [16:0] dy12, dx21, dy20, dx02, dy02;
  logic signed [17:0] pxd, pyd;
  logic signed [COORD_W-1:0] minx, maxx, miny, maxy;
  logic signed [COORD_W:0] tx0, tx1, ty0, ty1, cx0, cx1, cy0, cy1;

  trd_store_cmd_t st_cmd;
  logic [AW-1:0] st_addr;
  logic [Z_W-1:0] st_rdata;
  trd_div_req_t div_req;
  logic [NUM_W-1:0] div_num;
  logic div_done;
  logic [Z_W-1:0] div_quo;

  // handshakes
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_v_q || m_axis_tready_i;

  // vertex differences and sample offsets
  assign dy12 = 17'(y1_q) - 17'(y2_q);
  assign dx21 = 17'(x2_q) - 17'(x1_q);
  assign dy20 = 17'(y2_q) - 17'(y0_q);
  assign dx02 = 17'(x0_q) - 17'(x2_q);
  assign dy02 = 17'(y0_q) - 17'(y2_q);
  assign pxd  = $signed({11'b0, x_q, 4'b0}) - 18'(x2_q);
  assign pyd  = $signed({11'b0, y_q, 4'b0}) - 18'(y2_q);

  // bounding box clipped to the tile
  always_comb begin
    minx = (x0_q < x1_q) ? x0_q : x1_q;
    minx = (minx < x2_q) ? minx : x2_q;
    maxx = (x0_q > x1_q) ? x0_q : x1_q;
    maxx = (maxx > x2_q) ? maxx : x2_q;
    miny = (y0_q < y1_q) ? y0_q : y1_q;
    miny = (miny < y2_q) ? miny : y2_q;
    maxy = (y0_q > y1_q) ? y0_q : y1_q;
    maxy = (maxy > y2_q) ? maxy : y2_q;
    tx0 = q4_trunc(minx);
    tx1 = q4_trunc(maxx);
    ty0 = q4_trunc(miny);
    ty1 = q4_trunc(maxy);
    cx0 = (tx0 < 0) ? '0 : tx0;
    cy0 = (ty0 < 0) ? '0 : ty0;
    cx1 = (tx1 > $signed(17'(TILE_WIDTH - 1))) ? $signed(17'(TILE_WIDTH - 1)) : tx1;
    cy1 = (ty1 > $signed(17'(TILE_HEIGHT - 1))) ? $signed(17'(TILE_HEIGHT - 1)) : ty1;
    box_empty = (cx0 > cx1) || (cy0 > cy1);
  end

  // multiplier operand select
  always_comb begin
    ma  = '0;
    mb  = '0;
    msh = 1'b0;
    case (ph_q)
      PH_DEN: begin
        if (idx_q == 3'd0) begin
          ma = MA_W'(dy12); mb = MB_W'(dx02);
        end else begin
          ma = MA_W'(dx21); mb = MB_W'(dy02);
        end
      end
      PH_NA: begin
        if (idx_q == 3'd0) begin
          ma = MA_W'(dy12); mb = MB_W'(pxd);
        end else begin
          ma = MA_W'(dx21); mb = MB_W'(pyd);
        end
      end
      PH_NB: begin
        if (idx_q == 3'd0) begin
          ma = MA_W'(dy20); mb = MB_W'(pxd);
        end else begin
          ma = MA_W'(dx02); mb = MB_W'(pyd);
        end
      end
      PH_Z: begin
        case (idx_q)
          3'd0: begin ma = $signed({1'b0, z0_q}); mb = $signed({1'b0, na_q[HALF_W-1:0]}); end
          3'd1: begin
            ma = $signed({1'b0, z0_q}); mb = $signed({1'b0, na_q[DEN_W-1:HALF_W]}); msh = 1'b1;
          end
          3'd2: begin ma = $signed({1'b0, z1_q}); mb = $signed({1'b0, nb_q[HALF_W-1:0]}); end
          3'd3: begin
            ma = $signed({1'b0, z1_q}); mb = $signed({1'b0, nb_q[DEN_W-1:HALF_W]}); msh = 1'b1;
          end
          3'd4: begin ma = $signed({1'b0, z2_q}); mb = $signed({1'b0, ng_q[HALF_W-1:0]}); end
          default: begin
            ma = $signed({1'b0, z2_q}); mb = $signed({1'b0, ng_q[DEN_W-1:HALF_W]}); msh = 1'b1;
          end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(ma * mb);
  assign mac_n  = (ph_q == PH_Z) ? MAC_IDX_W'(6) : MAC_IDX_W'(2);

  // product aligned for the accumulator
  always_comb begin
    pext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (psh_q) begin
      pext = pext <<< HALF_W;
    end
  end

  // per-pixel conditions
  assign den_zero = (acc_q == '0);
  assign edge_val = neg_q ? EDGE_W'(-acc_q) : EDGE_W'(acc_q);
  assign ng_c     = $signed({2'b0, den_q}) - na_q - nb_q;
  assign covered  = !na_q[EDGE_W-1] && !nb_q[EDGE_W-1] && !ng_c[EDGE_W-1];
  assign pass     = d_q < st_rdata;
  assign scan_end = (y_q == by1_q) && (x_q == bx1_q);
  assign st_addr  = AW'(int'(y_q) * TILE_WIDTH + int'(x_q));
  assign cur      = '{x: x_q, y: y_q, depth: d_q, wa: wa_q, wb: wb_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc && (s_axis_tuser_i == REQ_RASTER)) state_d = S_MAC;
      end
      S_MAC: begin
        if (idx_q == mac_n) state_d = S_POST;
      end
      S_POST: begin
        case (ph_q)
          PH_DEN:  state_d = (den_zero || box_empty) ? S_IDLE : S_MAC;
          PH_NA:   state_d = S_MAC;
          PH_NB:   state_d = S_COVER;
          default: state_d = S_DDIV;
        endcase
      end
      S_COVER: state_d = covered ? S_MAC : S_NEXT;
      S_DDIV:  if (div_done) state_d = S_DTEST;
      S_DTEST: state_d = pass ? S_WDIVA : S_NEXT;
      S_WDIVA: if (div_done) state_d = S_WDIVB;
      S_WDIVB: if (div_done) state_d = S_PUSH;
      S_PUSH:  if (!pend_v_q || out_free) state_d = S_NEXT;
      S_NEXT:  state_d = scan_end ? S_FLUSH : S_MAC;
      S_FLUSH: if (!pend_v_q || out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ph_d      = ph_q;
    idx_d     = idx_q;
    acc_d     = pv_q ? acc_q + pext : acc_q;
    psh_d     = msh;
    pv_d      = 1'b0;
    den_d     = den_q;
    neg_d     = neg_q;
    na_d      = na_q;
    nb_d      = nb_q;
    ng_d      = ng_q;
    bx0_d     = bx0_q;
    bx1_d     = bx1_q;
    by0_d     = by0_q;
    by1_d     = by1_q;
    x_d       = x_q;
    y_d       = y_q;
    d_d       = d_q;
    wa_d      = wa_q;
    wb_d      = wb_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_last_d = out_last_q;
    out_load  = 1'b0;
    st_cmd    = '0;
    div_req   = '0;
    div_num   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i == REQ_CLEAR) begin
            st_cmd.clr = 1'b1;
          end else begin
            ph_d  = PH_DEN;
            idx_d = '0;
            acc_d = '0;
          end
        end
      end
      S_MAC: begin
        if (idx_q != mac_n) begin
          pv_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      S_POST: begin
        case (ph_q)
          PH_DEN: begin
            neg_d = acc_q[ACC_W-1];
            den_d = acc_q[ACC_W-1] ? DEN_W'(-acc_q) : DEN_W'(acc_q);
            bx0_d = cx0[PIX_W-1:0];
            bx1_d = cx1[PIX_W-1:0];
            by0_d = cy0[PIX_W-1:0];
            by1_d = cy1[PIX_W-1:0];
            x_d   = cx0[PIX_W-1:0];
            y_d   = cy0[PIX_W-1:0];
            ph_d  = PH_NA;
            idx_d = '0;
            acc_d = '0;
          end
          PH_NA: begin
            na_d  = edge_val;
            ph_d  = PH_NB;
            idx_d = '0;
            acc_d = '0;
          end
          PH_NB: begin
            nb_d = edge_val;
          end
          default: begin
            div_req.start = 1'b1;
            div_num       = acc_q[NUM_W-1:0];
          end
        endcase
      end
      S_COVER: begin
        ng_d = ng_c;
        if (covered) begin
          st_cmd.rd = 1'b1;
          ph_d  = PH_Z;
          idx_d = '0;
          acc_d = '0;
        end
      end
      S_DDIV: begin
        if (div_done) d_d = div_quo;
      end
      S_DTEST: begin
        if (pass) begin
          st_cmd.wr     = 1'b1;
          div_req.start = 1'b1;
          div_req.wmode = 1'b1;
          div_num       = NUM_W'({na_q[DEN_W-1:0], WT_FRAC'(0)});
        end
      end
      S_WDIVA: begin
        if (div_done) begin
          wa_d          = div_quo[WT_W-1:0];
          div_req.start = 1'b1;
          div_req.wmode = 1'b1;
          div_num       = NUM_W'({nb_q[DEN_W-1:0], WT_FRAC'(0)});
        end
      end
      S_WDIVB: begin
        if (div_done) wb_d = div_quo[WT_W-1:0];
      end
      S_PUSH: begin
        // hold one pixel back so the final one can carry tlast
        if (!pend_v_q) begin
          pend_d   = cur;
          pend_v_d = 1'b1;
        end else if (out_free) begin
          out_d      = pend_q;
          out_last_d = 1'b0;
          out_load   = 1'b1;
          pend_d     = cur;
        end
      end
      S_NEXT: begin
        if (!scan_end) begin
          if (y_q != by1_q) begin
            y_d = y_q + 1'b1;
          end else begin
            y_d = by0_q;
            x_d = x_q + 1'b1;
          end
          ph_d  = PH_NA;
          idx_d = '0;
          acc_d = '0;
        end
      end
      S_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_load   = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: begin
        pv_d = 1'b0;
      end
    endcase
    out_v_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_v_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= PH_DEN;
      idx_q    <= '0;
      pv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      idx_q    <= idx_d;
      pv_q     <= pv_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      x0_q <= s_axis_tdata_i[15:0];
      y0_q <= s_axis_tdata_i[31:16];
      z0_q <= s_axis_tdata_i[55:32];
      x1_q <= s_axis_tdata_i[71:56];
      y1_q <= s_axis_tdata_i[87:72];
      z1_q <= s_axis_tdata_i[111:88];
      x2_q <= s_axis_tdata_i[127:112];
      y2_q <= s_axis_tdata_i[143:128];
      z2_q <= s_axis_tdata_i[167:144];
    end
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    psh_q      <= psh_d;
    den_q      <= den_d;
    neg_q      <= neg_d;
    na_q       <= na_d;
    nb_q       <= nb_d;
    ng_q       <= ng_d;
    bx0_q      <= bx0_d;
    bx1_q      <= bx1_d;
    by0_q      <= by0_d;
    by1_q      <= by1_d;
    x_q        <= x_d;
    y_q        <= y_d;
    d_q        <= d_d;
    wa_q       <= wa_d;
    wb_q       <= wb_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  trd_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (st_cmd),
    .addr_i (st_addr),
    .wdata_i(d_q),
    .rdata_o(st_rdata)
  );

  trd_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .num_i (div_num),
    .den_i (den_q),
    .done_o(div_done),
    .quo_o (div_quo)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {2'b0, out_q.wb, out_q.wa, out_q.depth, out_q.y, out_q.x};

endmodule

>>> hw/rtl/trd_checker.sv
`timescale 1ns / 1ps
module trd_checker import trd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic             s_axis_tuser_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tlast_o
);

  // stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // a triangle beat makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_RASTER) |=> !s_axis_tready_o)
    else $error("ready stayed high after a triangle beat");

  // a clear beat completes at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_CLEAR) |=> s_axis_tready_o)
    else $error("clear beat did not complete in one cycle");

  // an emitted depth is always nearer than infinity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[29:6] != DEPTH_ONES)
    else $error("emitted depth is all ones");

  // weights never sum above one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (17'(m_axis_tdata_o[45:30]) + 17'(m_axis_tdata_o[61:46])) <= 17'h08000)
    else $error("weights exceed one");

endmodule

bind triangle_raster_depth_test_top trd_checker u_trd_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import trd_pkg::*;

  localparam int TW = 8;
  localparam int TH = 8;

  typedef struct {
    trd_pix_t pix;
    logic     last;
  } pix_beat_t;

  // expected pixel stream and a private copy of the depth store
  class pixel_scoreboard;
    pix_beat_t      pending[$];
    logic [Z_W-1:0] zbuf[TW*TH];
    int             errors;

    function new();
      errors = 0;
      foreach (zbuf[i]) zbuf[i] = DEPTH_ONES;
    endfunction

    // Q12.4 to whole pixels, toward zero
    function int to_pixel(int v);
      return (v >= 0) ? (v >>> 4) : -((-v) >>> 4);
    endfunction

    // rasterise one accepted beat into expected pixels, or clear the depth copy
    function void note_request(logic req, logic [IN_W-1:0] d);
      int x0, y0, x1, y1, x2, y2, bx0, by0, bx1, by1, px, py, idx, first;
      longint unsigned z0, z1, z2, dz, wa, wb;
      longint den, sgn, na, nb, ng;
      pix_beat_t b;
      if (req == REQ_CLEAR) begin
        foreach (zbuf[i]) zbuf[i] = DEPTH_ONES;
        return;
      end
      x0 = $signed(d[15:0]);    y0 = $signed(d[31:16]);   z0 = d[55:32];
      x1 = $signed(d[71:56]);   y1 = $signed(d[87:72]);   z1 = d[111:88];
      x2 = $signed(d[127:112]); y2 = $signed(d[143:128]); z2 = d[167:144];
      den = longint'(y1 - y2) * (x0 - x2) + longint'(x2 - x1) * (y0 - y2);
      if (den == 0) return;
      sgn = (den < 0) ? -1 : 1;
      den = den * sgn;
      bx0 = to_pixel((x0 < x1) ? ((x0 < x2) ? x0 : x2) : ((x1 < x2) ? x1 : x2));
      by0 = to_pixel((y0 < y1) ? ((y0 < y2) ? y0 : y2) : ((y1 < y2) ? y1 : y2));
      bx1 = to_pixel((x0 > x1) ? ((x0 > x2) ? x0 : x2) : ((x1 > x2) ? x1 : x2));
      by1 = to_pixel((y0 > y1) ? ((y0 > y2) ? y0 : y2) : ((y1 > y2) ? y1 : y2));
      if (bx0 < 0) bx0 = 0;
      if (by0 < 0) by0 = 0;
      if (bx1 > TW - 1) bx1 = TW - 1;
      if (by1 > TH - 1) by1 = TH - 1;
      first = pending.size();
      for (int x = bx0; x <= bx1; x++) begin
        for (int y = by0; y <= by1; y++) begin
          px = x * 16;
          py = y * 16;
          na = (longint'(y1 - y2) * (px - x2) + longint'(x2 - x1) * (py - y2)) * sgn;
          nb = (longint'(y2 - y0) * (px - x2) + longint'(x0 - x2) * (py - y2)) * sgn;
          ng = den - na - nb;
          if (na < 0 || nb < 0 || ng < 0) continue;
          dz = (z0 * na + z1 * nb + z2 * ng) / den;
          idx = y * TW + x;
          if (dz >= zbuf[idx]) continue;
          zbuf[idx] = dz[Z_W-1:0];
          wa = (longint'(na) << WT_FRAC) / den;
          wb = (longint'(nb) << WT_FRAC) / den;
          b.pix.x = x[PIX_W-1:0];
          b.pix.y = y[PIX_W-1:0];
          b.pix.depth = dz[Z_W-1:0];
          b.pix.wa = wa[WT_W-1:0];
          b.pix.wb = wb[WT_W-1:0];
          b.last = 1'b0;
          pending.push_back(b);
        end
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
    endfunction

    // compare one output beat with the oldest expected pixel
    function void check_pixel(logic [OUT_W-1:0] d, logic last);
      pix_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected pixel beat %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[2:0] != e.pix.x) begin
        $error("pixel_x exp %0d got %0d", e.pix.x, d[2:0]); errors++;
      end
      if (d[5:3] != e.pix.y) begin
        $error("pixel_y exp %0d got %0d", e.pix.y, d[5:3]); errors++;
      end
      if (d[29:6] != e.pix.depth) begin
        $error("depth exp %0d got %0d", e.pix.depth, d[29:6]); errors++;
      end
      if (d[45:30] != e.pix.wa) begin
        $error("weight_a exp %0d got %0d", e.pix.wa, d[45:30]); errors++;
      end
      if (d[61:46] != e.pix.wb) begin
        $error("weight_b exp %0d got %0d", e.pix.wb, d[61:46]); errors++;
      end
      if (last != e.last) begin
        $error("last exp %0d got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i = '0;
  logic             s_axis_tuser_i = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tlast_o;

  pixel_scoreboard sb = new();
  bit              calm = 1'b0;
  int              out_stall = 0;

  triangle_raster_depth_test_top #(.TILE_WIDTH(TW), .TILE_HEIGHT(TH)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver with random stalls after each beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_pixel(m_axis_tdata_o, m_axis_tlast_o);
        out_stall = calm ? 0 : $urandom_range(0, 7);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      m_axis_tready_i <= (out_stall == 0);
    end
  end

  // drive one request beat after a random gap
  task automatic send_req(logic req, int vx[3], int vy[3], int vz[3]);
    int gap;
    logic [IN_W-1:0] d;
    gap = calm ? 0 : $urandom_range(0, 7);
    for (int i = 0; i < 3; i++) begin
      d[56*i +: 16]      = vx[i][15:0];
      d[56*i + 16 +: 16] = vy[i][15:0];
      d[56*i + 32 +: 24] = vz[i][23:0];
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= req;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(req, d);
  endtask

  task automatic send_tri(int ax, int ay, int az, int bx, int by, int bz,
                          int cx, int cy, int cz);
    int vx[3], vy[3], vz[3];
    vx = '{ax, bx, cx}; vy = '{ay, by, cy}; vz = '{az, bz, cz};
    send_req(REQ_RASTER, vx, vy, vz);
  endtask

  task automatic send_clear();
    int vx[3], vy[3], vz[3];
    foreach (vx[i]) begin
      vx[i] = $urandom; vy[i] = $urandom; vz[i] = $urandom;
    end
    send_req(REQ_CLEAR, vx, vy, vz);
  endtask

  function automatic int near_coord(int base);
    return base + $urandom_range(0, 64) - 32;
  endfunction

  // stop sending and let every expected beat come out
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6000) @(posedge clk_i);
  endtask

  initial begin
    int sel, cx, cy, zmax;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: whole tile, repeat fails the strict test, clear, winding, edges
    calm = 1'b1;
    send_tri(0, 0, 1000, 256, 0, 2000, 0, 256, 3000);
    send_tri(0, 0, 1000, 256, 0, 2000, 0, 256, 3000);
    send_clear();
    send_tri(0, 0, 24'hFFFFFE, 0, 256, 24'hFFFFFE, 256, 0, 24'hFFFFFE);
    send_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
    calm = 1'b0;
    send_tri(16, 16, 5, 64, 64, 5, 112, 112, 5);
    send_tri(-32768, -32768, 7, -200, -32768, 7, -32768, -300, 7);
    send_tri(32767, 32767, 9, 200, 32767, 9, 32767, 300, 9);
    send_tri(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0);
    send_tri(-32768, 32767, 24'hFFFFFE, 32767, 32767, 0, 32767, -32768, 100);
    send_clear();
    send_tri(8, 8, 0, 120, 8, 24'hFFFFFE, 8, 120, 12345);
    send_tri(40, 40, 50, 40, 40, 50, 40, 40, 50);
    send_tri(-8, -8, 3, 20, 3, 4, 5, 30, 2);
    send_clear();

    // random: mostly local triangles, some noise, some clears
    for (int n = 0; n < 450; n++) begin
      calm = (n >= 150 && n < 200);
      if (n == 300) wait_drained();
      sel = $urandom_range(0, 99);
      zmax = ($urandom_range(0, 3) == 0) ? 24'hFFFFFE : $urandom_range(1, 4000);
      if (sel < 14) begin
        send_clear();
      end else if (sel < 24) begin
        send_tri($urandom, $urandom, $urandom_range(0, 24'hFFFFFE),
                 $urandom, $urandom, $urandom_range(0, 24'hFFFFFE),
                 $urandom, $urandom, $urandom_range(0, 24'hFFFFFE));
      end else if (sel < 29) begin
        cx = $urandom_range(0, 127);
        cy = $urandom_range(0, 127);
        send_tri(cx, cy, $urandom_range(0, zmax), cx + 16, cy + 16,
                 $urandom_range(0, zmax), cx + 32, cy + 32, $urandom_range(0, zmax));
      end else begin
        cx = $urandom_range(0, 140) - 10;
        cy = $urandom_range(0, 140) - 10;
        send_tri(near_coord(cx), near_coord(cy), $urandom_range(0, zmax),
                 near_coord(cx), near_coord(cy), $urandom_range(0, zmax),
                 near_coord(cx), near_coord(cy), $urandom_range(0, zmax));
      end
    end
    s_axis_tvalid_i <= 1'b0;
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
